>>> sv/wavhp_pkg.sv
// Package for the WAV header parser: parse phases, tags, GUID tables.
// No dependencies.
`default_nettype none
package wavhp_pkg;

  typedef enum logic [2:0] {
    PH_RIFF, PH_RLEN, PH_WAVE, PH_CTAG, PH_CLEN, PH_BODY, PH_DONE, PH_FAIL
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_DIV1, SQ_DIV2, SQ_DIV3, SQ_DIV4, SQ_OUT
  } seq_e;

  localparam logic [31:0] TagRiff = 32'h46464952;
  localparam logic [31:0] TagWave = 32'h45564157;
  localparam logic [31:0] TagFmt  = 32'h20746d66;
  localparam logic [31:0] TagData = 32'h61746164;
  localparam logic [31:0] TagBext = 32'h74786562;
  localparam logic [31:0] TagSmpl = 32'h6c706d73;
  localparam logic [15:0] FmtPcm   = 16'h0001;
  localparam logic [15:0] FmtFloat = 16'h0003;
  localparam logic [15:0] FmtExt   = 16'hfffe;

  localparam logic [1:0] StOpened = 2'd0;
  localparam logic [1:0] StNoRiff = 2'd1;
  localparam logic [1:0] StNoWave = 2'd2;
  localparam logic [1:0] StNoRate = 2'd3;

  function automatic logic [7:0] pcm_guid(input logic [3:0] i);
    case (i)
      4'd0: pcm_guid = 8'h01;
      4'd6: pcm_guid = 8'h10;
      4'd8: pcm_guid = 8'h80;
      4'd11: pcm_guid = 8'haa;
      4'd13: pcm_guid = 8'h38;
      4'd14: pcm_guid = 8'h9b;
      4'd15: pcm_guid = 8'h71;
      default: pcm_guid = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ambi_guid(input logic [3:0] i);
    case (i)
      4'd0: ambi_guid = 8'h01;
      4'd4: ambi_guid = 8'h21;
      4'd5: ambi_guid = 8'h07;
      4'd6: ambi_guid = 8'hd3;
      4'd7: ambi_guid = 8'h11;
      4'd8: ambi_guid = 8'h86;
      4'd9: ambi_guid = 8'h44;
      4'd10: ambi_guid = 8'hc8;
      4'd11: ambi_guid = 8'hc1;
      4'd12: ambi_guid = 8'hca;
      default: ambi_guid = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/wavhp_if.sv
// Stream channel interfaces for the WAV header parser.
// Depends on nothing; payload fields follow the block's byte and result items.
`default_nettype none
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       final_byte;
  modport source (output valid, file_byte, final_byte, input ready);
  modport sink (input valid, file_byte, final_byte, output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] sample_rate;
  logic [15:0] channel_count;
  logic [31:0] frame_bytes;
  logic [31:0] sample_bits;
  logic        float_samples;
  logic [32:0] data_offset;
  logic [31:0] data_bytes;
  logic [31:0] frame_count;
  modport source (output valid, status, sample_rate, channel_count, frame_bytes,
                  sample_bits, float_samples, data_offset, data_bytes, frame_count,
                  input ready);
  modport sink (input valid, status, sample_rate, channel_count, frame_bytes,
                sample_bits, float_samples, data_offset, data_bytes, frame_count,
                output ready);
endinterface
`default_nettype wire

>>> sv/wav_header_parser.sv
// Top level of the WAV header parser: byte-serial chunk walker plus divide sequencer.
// Depends on wavhp_pkg, wavhp_if and wavhp_div.
//
//   channel  | role | payload
//   in_ch    | sink | file_byte[7:0], final_byte
//   out_ch   | src  | status, rates, counts, data offset and length
//
// One byte is taken per cycle while the sequencer is idle. After the byte marked final,
// four divisions run in sequence on the shared one-bit-per-step divider, then the result
// waits in the output register until taken; input ready stays low meanwhile.
// Reset is asynchronous and active low, and clears all parse state.
`default_nettype none
module wav_header_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wavhp_in_if.sink    in_ch,
  wavhp_out_if.source out_ch
);
  wavhp_pkg::phase_e phase_q, phase_d;
  wavhp_pkg::seq_e   seq_q, seq_d;
  logic [33:0] pos_q, pos_d, rend_q, rend_d, cend_q, cend_d, dstart_q, dstart_d;
  logic [31:0] tag_q, tag_d;
  logic [5:0]  fsh_q, fsh_d;
  logic [15:0] fcode_q, fcode_d, chan_q, chan_d;
  logic [31:0] rate_q, rate_d, brate_q, brate_d, dlen_q, dlen_d;
  logic [63:0] rad_q, rad_d;
  logic        sup_q, sup_d, flt_q, flt_d;
  logic [1:0]  gm_q, gm_d, err_q, err_d;
  logic [31:0] q_q, q_d, dq_q, dq_d;
  logic [31:0] sbits_q, sbits_d, fcnt_q, fcnt_d;
  logic        ovalid_q, ovalid_d;

  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q;

  logic        acc;
  logic [7:0]  b;
  logic [33:0] nxt, span, lenw, shifted;
  logic [4:0]  sh;
  logic [31:0] len;
  logic [5:0]  off;
  logic [15:0] fc_new;
  logic        known;

  wavhp_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_q)
  );

  assign in_ch.ready = (seq_q == wavhp_pkg::SQ_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign b   = in_ch.file_byte;
  assign nxt = pos_q + 34'd1;
  assign sh  = {fsh_q[1:0], 3'b000};
  assign shifted = {26'd0, b} << sh;

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; rend_d = rend_q; cend_d = cend_q;
    dstart_d = dstart_q; tag_d = tag_q; fsh_d = fsh_q; fcode_d = fcode_q;
    chan_d = chan_q; rate_d = rate_q; brate_d = brate_q; dlen_d = dlen_q;
    rad_d = rad_q; sup_d = sup_q; flt_d = flt_q; gm_d = gm_q; err_d = err_q;
    len = cend_q[31:0]; lenw = 34'd0; span = 34'd0; off = fsh_q; fc_new = fcode_q;
    known = 1'b0;
    if (acc) begin
      pos_d = nxt;
      case (phase_q)
        wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE, wavhp_pkg::PH_CTAG: begin
          tag_d = tag_q | shifted[31:0];
          fsh_d = fsh_q + 6'd1;
          if (fsh_q[1:0] == 2'd3) begin
            fsh_d = 6'd0;
            if (phase_q == wavhp_pkg::PH_CTAG) begin
              phase_d = wavhp_pkg::PH_CLEN;
              cend_d  = 34'd0;
            end else if (phase_q == wavhp_pkg::PH_RIFF) begin
              if (tag_d == wavhp_pkg::TagRiff) begin
                phase_d = wavhp_pkg::PH_RLEN;
                rend_d  = 34'd0;
              end else begin
                err_d = wavhp_pkg::StNoRiff; phase_d = wavhp_pkg::PH_FAIL;
              end
            end else if (tag_d == wavhp_pkg::TagWave) begin
              tag_d = 32'd0;
              phase_d = (nxt < rend_q) ? wavhp_pkg::PH_CTAG : wavhp_pkg::PH_DONE;
            end else begin
              err_d = wavhp_pkg::StNoWave; phase_d = wavhp_pkg::PH_FAIL;
            end
          end
        end
        wavhp_pkg::PH_RLEN: begin
          rend_d = rend_q | shifted;
          fsh_d  = fsh_q + 6'd1;
          if (fsh_q[1:0] == 2'd3) begin
            rend_d = nxt + rend_d;
            fsh_d = 6'd0; tag_d = 32'd0; phase_d = wavhp_pkg::PH_WAVE;
          end
        end
        wavhp_pkg::PH_CLEN: begin
          cend_d = cend_q | shifted;
          fsh_d  = fsh_q + 6'd1;
          if (fsh_q[1:0] == 2'd3) begin
            len   = cend_d[31:0];
            lenw  = {2'b00, len};
            span  = lenw + {33'd0, len[0]};
            known = tag_q == wavhp_pkg::TagFmt || tag_q == wavhp_pkg::TagData ||
                    tag_q == wavhp_pkg::TagBext || tag_q == wavhp_pkg::TagSmpl;
            cend_d = nxt + span;
            fsh_d  = 6'd0;
            if (tag_q == wavhp_pkg::TagFmt) begin
              fcode_d = 16'd0; chan_d = 16'd0; rate_d = 32'd0; brate_d = 32'd0;
              sup_d = 1'b0; gm_d = 2'b11;
            end else if (tag_q == wavhp_pkg::TagData) begin
              dlen_d = len; dstart_d = nxt;
              rad_d = sup_q ? {brate_q, rate_q} : 64'd0;
            end
            if (span == 34'd0) begin
              if (known) begin
                tag_d = 32'd0;
                phase_d = (nxt < rend_q) ? wavhp_pkg::PH_CTAG : wavhp_pkg::PH_DONE;
              end else begin
                phase_d = wavhp_pkg::PH_DONE;
              end
            end else begin
              phase_d = wavhp_pkg::PH_BODY;
            end
          end
        end
        wavhp_pkg::PH_BODY: begin
          if (tag_q == wavhp_pkg::TagFmt) begin
            if (off < 6'd2) begin
              fc_new = fcode_q | (off[0] ? {b, 8'h00} : {8'h00, b});
              fcode_d = fc_new;
              if (off == 6'd1 && fc_new == wavhp_pkg::FmtFloat) flt_d = 1'b1;
            end else if (off < 6'd4) begin
              chan_d = chan_q | (off[0] ? {b, 8'h00} : {8'h00, b});
            end else if (off < 6'd8) begin
              rate_d = rate_q | shifted[31:0];
            end else if (off < 6'd12) begin
              brate_d = brate_q | shifted[31:0];
            end
            if (off == 6'd15)
              sup_d = (fcode_q == wavhp_pkg::FmtPcm || fcode_q == wavhp_pkg::FmtFloat);
            if (off >= 6'd24 && off < 6'd40) begin
              if (b != wavhp_pkg::pcm_guid(off[3:0] + 4'd8)) gm_d[0] = 1'b0;
              if (b != wavhp_pkg::ambi_guid(off[3:0] + 4'd8)) gm_d[1] = 1'b0;
              if (off == 6'd39 && fcode_q == wavhp_pkg::FmtExt && gm_d != 2'b00)
                sup_d = 1'b1;
            end
          end
          if (fsh_q < 6'd40) fsh_d = fsh_q + 6'd1;
          if (nxt == cend_q) begin
            fsh_d = 6'd0; tag_d = 32'd0;
            phase_d = (nxt < rend_q) ? wavhp_pkg::PH_CTAG : wavhp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Division order: q, 8q/channels, data divisor, frame count.
  always_comb begin
    seq_d = seq_q; ovalid_d = ovalid_q;
    q_d = q_q; dq_d = dq_q; sbits_d = sbits_q; fcnt_d = fcnt_q;
    div_start = 1'b0; div_a = brate_q; div_b = rate_q;
    case (seq_q)
      wavhp_pkg::SQ_IDLE: begin
        if (acc && in_ch.final_byte) begin
          seq_d = wavhp_pkg::SQ_DIV1;
          div_start = 1'b1;
          div_a = brate_d; div_b = rate_d;
        end
      end
      wavhp_pkg::SQ_DIV1: begin
        div_a = {div_q[28:0], 3'b000}; div_b = {16'd0, chan_q};
        if (div_done) begin
          q_d = div_q; div_start = 1'b1; seq_d = wavhp_pkg::SQ_DIV2;
        end
      end
      wavhp_pkg::SQ_DIV2: begin
        div_a = rad_q[63:32]; div_b = rad_q[31:0];
        if (div_done) begin
          sbits_d = div_q; div_start = 1'b1; seq_d = wavhp_pkg::SQ_DIV3;
        end
      end
      wavhp_pkg::SQ_DIV3: begin
        div_a = dlen_q; div_b = div_q;
        if (div_done) begin
          dq_d = div_q; div_start = 1'b1; seq_d = wavhp_pkg::SQ_DIV4;
        end
      end
      wavhp_pkg::SQ_DIV4: begin
        if (div_done) begin
          fcnt_d = div_q; ovalid_d = 1'b1; seq_d = wavhp_pkg::SQ_OUT;
        end
      end
      wavhp_pkg::SQ_OUT: begin
        if (out_ch.ready) begin
          ovalid_d = 1'b0; seq_d = wavhp_pkg::SQ_IDLE;
        end
      end
      default: seq_d = wavhp_pkg::SQ_IDLE;
    endcase
  end

  // Parse state clears once the result is taken, ready for a new file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavhp_pkg::PH_RIFF; seq_q <= wavhp_pkg::SQ_IDLE; ovalid_q <= 1'b0;
      pos_q <= '0; rend_q <= '0; cend_q <= '0; dstart_q <= '0; tag_q <= '0;
      fsh_q <= '0; fcode_q <= '0; chan_q <= '0; rate_q <= '0; brate_q <= '0;
      dlen_q <= '0; rad_q <= '0; sup_q <= 1'b0; flt_q <= 1'b0; gm_q <= 2'b11;
      err_q <= '0;
    end else begin
      seq_q <= seq_d; ovalid_q <= ovalid_d;
      if (seq_q == wavhp_pkg::SQ_OUT && out_ch.ready) begin
        phase_q <= wavhp_pkg::PH_RIFF;
        pos_q <= '0; rend_q <= '0; cend_q <= '0; dstart_q <= '0; tag_q <= '0;
        fsh_q <= '0; fcode_q <= '0; chan_q <= '0; rate_q <= '0; brate_q <= '0;
        dlen_q <= '0; rad_q <= '0; sup_q <= 1'b0; flt_q <= 1'b0; gm_q <= 2'b11;
        err_q <= '0;
      end else begin
        phase_q <= phase_d; pos_q <= pos_d; rend_q <= rend_d; cend_q <= cend_d;
        dstart_q <= dstart_d; tag_q <= tag_d; fsh_q <= fsh_d; fcode_q <= fcode_d;
        chan_q <= chan_d; rate_q <= rate_d; brate_q <= brate_d; dlen_q <= dlen_d;
        rad_q <= rad_d; sup_q <= sup_d; flt_q <= flt_d; gm_q <= gm_d; err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; dq_q <= dq_d; sbits_q <= sbits_d; fcnt_q <= fcnt_d;
  end

  assign out_ch.valid         = ovalid_q;
  assign out_ch.status        = (err_q != wavhp_pkg::StOpened) ? err_q :
                                ((rate_q == 32'd0) ? wavhp_pkg::StNoRate
                                                   : wavhp_pkg::StOpened);
  assign out_ch.sample_rate   = rate_q;
  assign out_ch.channel_count = chan_q;
  assign out_ch.frame_bytes   = sup_q ? q_q : 32'd0;
  assign out_ch.sample_bits   = sbits_q;
  assign out_ch.float_samples = flt_q;
  assign out_ch.data_offset   = dstart_q[32:0];
  assign out_ch.data_bytes    = dlen_q;
  assign out_ch.frame_count   = fcnt_q + {31'd0, dq_q[0] & 1'b0};
endmodule
`default_nettype wire

>>> sv/wavhp_div.sv
// Shared 32-bit restoring divider, one quotient bit per cycle.
// Depends on nothing; a zero divisor yields a zero quotient.
`default_nettype none
module wavhp_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);
  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        zero_q, zero_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    zero_d = zero_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      quo_d  = dividend_i;
      rem_d  = 32'd0;
      dvs_d  = divisor_i;
      zero_d = (divisor_i == 32'd0);
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? 32'd0 : quo_q;
endmodule
`default_nettype wire
